FILE: hdl/ssa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the shift score accumulator.
// No dependencies.
package ssa_pkg;

  localparam logic [3:0] KIND_FWD_BOUNDS = 4'd0;
  localparam logic [3:0] KIND_REV_BOUNDS = 4'd1;
  localparam logic [3:0] KIND_FWD_ENTRY  = 4'd2;
  localparam logic [3:0] KIND_REV_ENTRY  = 4'd3;
  localparam logic [3:0] KIND_RANGE      = 4'd4;
  localparam logic [3:0] KIND_CLEAR      = 4'd5;
  localparam logic [3:0] KIND_PEAK       = 4'd6;
  localparam logic [3:0] KIND_PRECURSOR  = 4'd7;
  localparam logic [3:0] KIND_READ       = 4'd8;

  localparam logic [1:0] REG_COL_COUNT   = 2'd0;
  localparam logic [1:0] REG_WATER_SHIFT = 2'd1;
  localparam logic [1:0] REG_BONUS       = 2'd2;
  localparam logic [1:0] REG_ACETYL      = 2'd3;

  localparam logic [14:0] SCORE_MAX = 15'h7FFF;

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b000000000001,
    ST_CLEAR   = 12'b000000000010,
    ST_W_SETUP = 12'b000000000100,
    ST_W_FIRST = 12'b000000001000,
    ST_W_LAST  = 12'b000000010000,
    ST_W_ENT   = 12'b000000100000,
    ST_W_ROW   = 12'b000001000000,
    ST_W_UPD   = 12'b000010000000,
    ST_R_RANGE = 12'b000100000000,
    ST_R_ISSUE = 12'b001000000000,
    ST_R_ACC   = 12'b010000000000,
    ST_R_DONE  = 12'b100000000000
  } state_t;

endpackage

FILE: hdl/shift_score_accumulator_core.sv
`timescale 1ns / 1ps
// Top level of the shift score accumulator: control sequencer and table memories.
// Depends on ssa_pkg and ssa_ram.
//
// A table load is written as it is taken. A peak or precursor walks one or two
// windows; a window that leaves the columns ends in the setup state, any other
// goes through bound lookup and end check, then a row fetch and score update per
// index entry (no update for a row past ROWS), all set by the single read port of
// the bounds, entry and score memories. A read looks up the row range, then scans
// each row of the proteoform, and holds while the previous result beat still waits.
// After reset and on every clear item the score memories are swept, one row a cycle,
// through all ROWS rows, taking no item; configuration writes are taken at all times.
module shift_score_accumulator_core #(
  parameter int COLUMNS     = 65536,
  parameter int ENTRIES     = 262144,
  parameter int ROWS        = 65536,
  parameter int PROTEOFORMS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         kind,
  input  logic [15:0]        column,
  input  logic [18:0]        entry_begin,
  input  logic signed [18:0] entry_end,
  input  logic [17:0]        entry_pos,
  input  logic [15:0]        row,
  input  logic [9:0]         proteo_id,
  input  logic [15:0]        row_begin,
  input  logic [15:0]        row_end,
  input  logic [23:0]        mass,
  input  logic [15:0]        tolerance,
  input  logic               last_peak,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         out_proteo_id,
  output logic [15:0]        complete_score,
  output logic [15:0]        prefix_score,
  output logic [15:0]        suffix_score,
  output logic [15:0]        internal_score
);

  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PW = (PROTEOFORMS > 1) ? $clog2(PROTEOFORMS) : 1;

  ssa_pkg::state_t state;

  logic [16:0] col_count;
  logic [15:0] water_shift;
  logic [9:0]  precursor_bonus;
  logic        acetyl_mode;

  logic [3:0]  kind_q;
  logic [23:0] mass_q;
  logic [15:0] tol_q;
  logic        last_q;
  logic [9:0]  pid_q;
  logic        pass;

  logic [CW-1:0]     right_addr;
  logic [18:0]       ent_j;
  logic [18:0]       ent_end;
  logic [15:0]       row_q;
  logic [RW-1:0]     clr_cnt;
  logic [15:0]       rd_bgn;
  logic [15:0]       rd_end;
  logic [17:0]       rd_pref;
  logic [16:0]       rd_j;
  logic [14:0]       best;
  logic [14:0]       best_pref;
  logic [14:0]       best_rev;
  logic [14:0]       best_suff;

  logic        in_fire;
  logic        is_peak;
  logic        col_ok;
  logic        pos_ok;
  logic        pid_ok;
  logic        use_shift;
  logic signed [26:0] center;
  logic signed [26:0] win_left;
  logic signed [26:0] win_right;
  logic [25:0] left_u;
  logic        skip;
  logic        more_pass;
  logic        ent_go;
  logic [15:0] ent_row;
  logic [14:0] cur_score;
  logic [9:0]  add_val;
  logic [15:0] sum;
  logic [14:0] sat_score;
  logic [17:0] pref_raw;
  logic        rd_go;
  logic [14:0] rd_f;
  logic [14:0] rd_r;
  logic        out_load;

  logic [37:0]   fwd_col_rdata;
  logic [37:0]   rev_col_rdata;
  logic [37:0]   col_rdata;
  logic [CW-1:0] col_raddr;
  logic [15:0]   fwd_ent_rdata;
  logic [15:0]   rev_ent_rdata;
  logic [31:0]   range_rdata;
  logic [14:0]   fwd_sc_rdata;
  logic [14:0]   rev_sc_rdata;
  logic [RW-1:0] sc_raddr;
  logic [RW-1:0] sc_waddr;
  logic [14:0]   sc_wdata;
  logic          fwd_sc_we;
  logic          rev_sc_we;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ssa_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;

  assign col_ok = 32'(column) < COLUMNS;
  assign pos_ok = 32'(entry_pos) < ENTRIES;
  assign pid_ok = 32'(proteo_id) < PROTEOFORMS;

  assign is_peak   = (kind_q == ssa_pkg::KIND_PEAK);
  assign use_shift = is_peak && pass;
  assign center    = $signed({3'b000, mass_q}) - (use_shift ? $signed({11'd0, water_shift})
                                                            : 27'sd0);
  assign win_left  = center - $signed({11'd0, tol_q});
  assign win_right = center + $signed({11'd0, tol_q});
  assign left_u    = win_left[26] ? 26'd0 : win_left[25:0];
  assign skip      = win_right[26] || (win_right[25:0] >= 26'(col_count)) ||
                     (32'(win_right[25:0]) >= COLUMNS);
  assign more_pass = !pass && !(is_peak && last_q);

  assign col_rdata = pass ? rev_col_rdata : fwd_col_rdata;
  assign col_raddr = (state == ssa_pkg::ST_W_SETUP) ? CW'(left_u) : right_addr;

  assign ent_go  = ($signed({1'b0, ent_j}) <= $signed({ent_end[18], ent_end})) &&
                   (32'(ent_j) < ENTRIES);
  assign ent_row = pass ? rev_ent_rdata : fwd_ent_rdata;

  assign cur_score = pass ? rev_sc_rdata : fwd_sc_rdata;
  assign add_val   = is_peak ? 10'd1 : precursor_bonus;
  assign sum       = {1'b0, cur_score} + {6'd0, add_val};
  assign sat_score = sum[15] ? ssa_pkg::SCORE_MAX : sum[14:0];

  assign pref_raw = {2'b00, range_rdata[31:16]} + 18'd1 + {17'd0, acetyl_mode};
  assign rd_go    = (rd_j <= {1'b0, rd_end}) && (32'(rd_j) < ROWS);
  assign rd_f     = fwd_sc_rdata;
  assign rd_r     = rev_sc_rdata;
  assign out_load = (state == ssa_pkg::ST_R_DONE) && (!out_valid || out_ready);

  assign sc_raddr  = (state == ssa_pkg::ST_W_ROW) ? RW'(ent_row) : RW'(rd_j);
  assign sc_waddr  = (state == ssa_pkg::ST_CLEAR) ? clr_cnt : RW'(row_q);
  assign sc_wdata  = (state == ssa_pkg::ST_CLEAR) ? 15'd0 : sat_score;
  assign fwd_sc_we = (state == ssa_pkg::ST_CLEAR) || ((state == ssa_pkg::ST_W_UPD) && !pass);
  assign rev_sc_we = (state == ssa_pkg::ST_CLEAR) || ((state == ssa_pkg::ST_W_UPD) && pass);

  ssa_ram #(.WIDTH(38), .DEPTH(COLUMNS)) u_fwd_col (
    .clk   (clk),
    .we    (in_fire && (kind == ssa_pkg::KIND_FWD_BOUNDS) && col_ok),
    .waddr (CW'(column)),
    .wdata ({entry_begin, entry_end}),
    .raddr (col_raddr),
    .rdata (fwd_col_rdata)
  );

  ssa_ram #(.WIDTH(38), .DEPTH(COLUMNS)) u_rev_col (
    .clk   (clk),
    .we    (in_fire && (kind == ssa_pkg::KIND_REV_BOUNDS) && col_ok),
    .waddr (CW'(column)),
    .wdata ({entry_begin, entry_end}),
    .raddr (col_raddr),
    .rdata (rev_col_rdata)
  );

  ssa_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_fwd_ent (
    .clk   (clk),
    .we    (in_fire && (kind == ssa_pkg::KIND_FWD_ENTRY) && pos_ok),
    .waddr (EW'(entry_pos)),
    .wdata (row),
    .raddr (EW'(ent_j)),
    .rdata (fwd_ent_rdata)
  );

  ssa_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_rev_ent (
    .clk   (clk),
    .we    (in_fire && (kind == ssa_pkg::KIND_REV_ENTRY) && pos_ok),
    .waddr (EW'(entry_pos)),
    .wdata (row),
    .raddr (EW'(ent_j)),
    .rdata (rev_ent_rdata)
  );

  ssa_ram #(.WIDTH(32), .DEPTH(PROTEOFORMS)) u_range (
    .clk   (clk),
    .we    (in_fire && (kind == ssa_pkg::KIND_RANGE) && pid_ok),
    .waddr (PW'(proteo_id)),
    .wdata ({row_begin, row_end}),
    .raddr (PW'(proteo_id)),
    .rdata (range_rdata)
  );

  ssa_ram #(.WIDTH(15), .DEPTH(ROWS)) u_fwd_score (
    .clk   (clk),
    .we    (fwd_sc_we),
    .waddr (sc_waddr),
    .wdata (sc_wdata),
    .raddr (sc_raddr),
    .rdata (fwd_sc_rdata)
  );

  ssa_ram #(.WIDTH(15), .DEPTH(ROWS)) u_rev_score (
    .clk   (clk),
    .we    (rev_sc_we),
    .waddr (sc_waddr),
    .wdata (sc_wdata),
    .raddr (sc_raddr),
    .rdata (rev_sc_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count       <= 17'd65536;
      water_shift     <= 16'd1802;
      precursor_bonus <= 10'd10;
      acetyl_mode     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ssa_pkg::REG_COL_COUNT:   col_count       <= cfg_data;
        ssa_pkg::REG_WATER_SHIFT: water_shift     <= cfg_data[15:0];
        ssa_pkg::REG_BONUS:       precursor_bonus <= cfg_data[9:0];
        ssa_pkg::REG_ACETYL:      acetyl_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_q <= kind;
      mass_q <= mass;
      tol_q  <= tolerance;
      last_q <= last_peak;
      pid_q  <= proteo_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ssa_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      pass      <= 1'b0;
    end else begin
      unique case (state)
        ssa_pkg::ST_IDLE: begin
          if (in_fire) begin
            pass <= 1'b0;
            priority if (kind == ssa_pkg::KIND_CLEAR) begin
              clr_cnt <= '0;
              state   <= ssa_pkg::ST_CLEAR;
            end else if (kind == ssa_pkg::KIND_PEAK || kind == ssa_pkg::KIND_PRECURSOR) begin
              state <= ssa_pkg::ST_W_SETUP;
            end else if (kind == ssa_pkg::KIND_READ && pid_ok) begin
              state <= ssa_pkg::ST_R_RANGE;
            end else begin
              state <= ssa_pkg::ST_IDLE;
            end
          end
        end
        ssa_pkg::ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (32'(clr_cnt) == ROWS - 1) begin
            state <= ssa_pkg::ST_IDLE;
          end
        end
        ssa_pkg::ST_W_SETUP: begin
          right_addr <= CW'(win_right[25:0]);
          if (skip) begin
            pass  <= 1'b1;
            state <= more_pass ? ssa_pkg::ST_W_SETUP : ssa_pkg::ST_IDLE;
          end else begin
            state <= ssa_pkg::ST_W_FIRST;
          end
        end
        ssa_pkg::ST_W_FIRST: begin
          ent_j <= col_rdata[37:19];
          state <= ssa_pkg::ST_W_LAST;
        end
        ssa_pkg::ST_W_LAST: begin
          ent_end <= col_rdata[18:0];
          state   <= ssa_pkg::ST_W_ENT;
        end
        ssa_pkg::ST_W_ENT: begin
          if (ent_go) begin
            ent_j <= ent_j + 19'd1;
            state <= ssa_pkg::ST_W_ROW;
          end else begin
            pass  <= 1'b1;
            state <= more_pass ? ssa_pkg::ST_W_SETUP : ssa_pkg::ST_IDLE;
          end
        end
        ssa_pkg::ST_W_ROW: begin
          row_q <= ent_row;
          state <= (32'(ent_row) < ROWS) ? ssa_pkg::ST_W_UPD : ssa_pkg::ST_W_ENT;
        end
        ssa_pkg::ST_W_UPD: begin
          state <= ssa_pkg::ST_W_ENT;
        end
        ssa_pkg::ST_R_RANGE: begin
          rd_bgn    <= range_rdata[31:16];
          rd_end    <= range_rdata[15:0];
          rd_j      <= {1'b0, range_rdata[31:16]};
          rd_pref   <= (pref_raw > {2'b00, range_rdata[15:0]}) ? {2'b00, range_rdata[15:0]}
                                                                 : pref_raw;
          best      <= '0;
          best_pref <= '0;
          best_rev  <= '0;
          best_suff <= '0;
          state     <= ssa_pkg::ST_R_ISSUE;
        end
        ssa_pkg::ST_R_ISSUE: begin
          state <= rd_go ? ssa_pkg::ST_R_ACC : ssa_pkg::ST_R_DONE;
        end
        ssa_pkg::ST_R_ACC: begin
          if (rd_f > best) begin
            best <= rd_f;
          end
          if ({1'b0, rd_j} <= rd_pref && rd_f > best_pref) begin
            best_pref <= rd_f;
          end
          if (rd_r > best_rev) begin
            best_rev <= rd_r;
          end
          if (rd_j == {1'b0, rd_bgn} && rd_r > best_suff) begin
            best_suff <= rd_r;
          end
          rd_j  <= rd_j + 17'd1;
          state <= ssa_pkg::ST_R_ISSUE;
        end
        ssa_pkg::ST_R_DONE: begin
          if (out_load) begin
            state <= ssa_pkg::ST_IDLE;
          end
        end
        default: state <= ssa_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_proteo_id  <= pid_q;
      complete_score <= {1'b0, best_pref} + {1'b0, best_suff};
      prefix_score   <= {1'b0, best_pref} + {1'b0, best_rev};
      suffix_score   <= {1'b0, best} + {1'b0, best_suff};
      internal_score <= {1'b0, best} + {1'b0, best_rev};
    end
  end

endmodule

FILE: hdl/ssa_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module ssa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
